// ===== rtl/bplru_pkg.sv =====
// Shared constants, codes and control types of the LRU buffer pool allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package bplru_pkg;

  // Pool geometry
  localparam int POOL_SLOTS = 8;
  localparam int DIM_BITS   = 16;
  localparam int SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int TIME_W     = 32;
  localparam int DIMS_W     = 2 * DIM_BITS;

  // Input item layout in in_tdata (command travels in in_tuser)
  localparam int IN_TDATA_W = 72;
  localparam int IN_TUSER_W = 2;
  localparam int W_LSB      = 0;
  localparam int H_LSB      = 16;
  localparam int NOW_LSB    = 32;
  localparam int OK_BIT     = 64;
  localparam int IDX_LSB    = 65;
  localparam int IDX_W      = 3;

  // Result item layout in out_tdata
  localparam int OUT_TDATA_W = 8;
  localparam int ST_W        = 3;
  localparam int GRANT_W     = 3;

  // Commands
  localparam logic [1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_FLUSH   = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_REUSED     = 3'd0;
  localparam logic [2:0] ST_FILLED     = 3'd1;
  localparam logic [2:0] ST_REPLACED   = 3'd2;
  localparam logic [2:0] ST_NONE_FREE  = 3'd3;
  localparam logic [2:0] ST_ALLOC_FAIL = 3'd4;
  localparam logic [2:0] ST_RELEASED   = 3'd5;
  localparam logic [2:0] ST_NOT_POOLED = 3'd6;
  localparam logic [2:0] ST_FLUSHED    = 3'd7;

  typedef logic [SLOT_W-1:0] slot_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture the input item, clear the scan trackers
    logic scan_step;  // issue a slot read and advance the scan counter
    logic exec;       // commit the decision and load the result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_acq;     // offered item is an acquire
    logic scan_last;  // the read issued now is the last slot
    logic out_free;   // result register can take a new item
  } ctrl_sts_t;

endpackage

// ===== rtl/bplru_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; no package needed.
module bplru_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bplru_ctrl.sv =====
// Sequencer of the buffer pool allocator: accept, slot scan, commit.
// Depends on bplru_pkg for the command and status structs.
module bplru_ctrl
  import bplru_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.in_acq ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        // last slot's read data is evaluated here
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/bplru_dp.sv =====
// Datapath of the buffer pool allocator: slot marks, slot RAMs, scan trackers,
// decision logic and result register. Depends on bplru_pkg and bplru_ram.
module bplru_dp
  import bplru_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  ctrl_cmd_t              cmd,
  output ctrl_sts_t              sts
);

  // Captured request
  logic [1:0]          req_cmd_r;
  logic [DIM_BITS-1:0] req_w_r;
  logic [DIM_BITS-1:0] req_h_r;
  logic [TIME_W-1:0]   req_now_r;
  logic                req_ok_r;
  logic [IDX_W-1:0]    req_idx_r;

  // Slot marks
  logic [POOL_SLOTS-1:0] valid_r;
  logic [POOL_SLOTS-1:0] busy_r;

  // Scan
  slot_t scan_r;
  slot_t rd_idx_r;
  logic  rd_vld_r;

  // Trackers
  logic              hit_found_r;
  slot_t             hit_idx_r;
  logic              emp_found_r;
  slot_t             emp_idx_r;
  logic              vic_found_r;
  slot_t             vic_idx_r;
  logic [TIME_W-1:0] vic_last_r;

  // RAM ports
  logic [DIMS_W-1:0] dims_rd;
  logic [TIME_W-1:0] time_rd;
  logic              dims_we;
  logic              time_we;
  slot_t             wr_slot;

  // Decision
  logic [ST_W-1:0]    res_status;
  logic [GRANT_W-1:0] res_grant;
  logic               res_disc;
  logic               set_vb;     // mark wr_slot valid and busy
  logic               set_busy;   // mark wr_slot busy only
  logic               clr_busy;   // clear busy of wr_slot
  logic               clr_slot;   // clear valid and busy of wr_slot
  logic               clr_all;
  slot_t              rel_slot;
  logic               rel_ok;

  // Result register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  assign rel_slot = SLOT_W'(req_idx_r);
  assign rel_ok   = (32'(req_idx_r) < POOL_SLOTS) && valid_r[rel_slot];

  // Status to controller
  assign sts.in_acq    = (in_tuser == CMD_ACQUIRE);
  assign sts.scan_last = (scan_r == SLOT_W'(POOL_SLOTS - 1));
  assign sts.out_free  = !out_valid_r || out_tready;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_cmd_r <= in_tuser;
      req_w_r   <= in_tdata[W_LSB +: DIM_BITS];
      req_h_r   <= in_tdata[H_LSB +: DIM_BITS];
      req_now_r <= in_tdata[NOW_LSB +: TIME_W];
      req_ok_r  <= in_tdata[OK_BIT];
      req_idx_r <= in_tdata[IDX_LSB +: IDX_W];
    end
  end

  // Slot size and last-use stores
  bplru_ram #(.WIDTH(DIMS_W), .DEPTH(POOL_SLOTS)) u_dims_ram (
    .clk   (clk),
    .we    (dims_we),
    .waddr (wr_slot),
    .wdata ({req_h_r, req_w_r}),
    .raddr (scan_r),
    .rdata (dims_rd)
  );

  bplru_ram #(.WIDTH(TIME_W), .DEPTH(POOL_SLOTS)) u_time_ram (
    .clk   (clk),
    .we    (time_we),
    .waddr (wr_slot),
    .wdata (req_now_r),
    .raddr (scan_r),
    .rdata (time_rd)
  );

  // Scan counter and read-data tag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_r <= '0;
    end else if (cmd.scan_step) begin
      scan_r <= scan_r + 1'b1;
    end
    rd_idx_r <= scan_r;
  end

  // Trackers: first size match, first empty slot, oldest free slot
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_found_r <= 1'b0;
      emp_found_r <= 1'b0;
      vic_found_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (!hit_found_r && valid_r[rd_idx_r] && !busy_r[rd_idx_r]
          && dims_rd == {req_h_r, req_w_r}) begin
        hit_found_r <= 1'b1;
        hit_idx_r   <= rd_idx_r;
      end
      if (!emp_found_r && !valid_r[rd_idx_r]) begin
        emp_found_r <= 1'b1;
        emp_idx_r   <= rd_idx_r;
      end
      if (!busy_r[rd_idx_r] && (!vic_found_r || time_rd < vic_last_r)) begin
        vic_found_r <= 1'b1;
        vic_idx_r   <= rd_idx_r;
        vic_last_r  <= time_rd;
      end
    end
  end

  // Decision for the captured command
  always_comb begin
    res_status = ST_NOT_POOLED;
    res_grant  = '0;
    res_disc   = 1'b0;
    wr_slot    = '0;
    dims_we    = 1'b0;
    time_we    = 1'b0;
    set_vb     = 1'b0;
    set_busy   = 1'b0;
    clr_busy   = 1'b0;
    clr_slot   = 1'b0;
    clr_all    = 1'b0;
    case (req_cmd_r)
      CMD_ACQUIRE: begin
        if (hit_found_r) begin
          wr_slot    = hit_idx_r;
          time_we    = cmd.exec;
          set_busy   = 1'b1;
          res_status = ST_REUSED;
          res_grant  = GRANT_W'(hit_idx_r);
        end else if (emp_found_r) begin
          wr_slot   = emp_idx_r;
          res_grant = GRANT_W'(emp_idx_r);
          if (req_ok_r) begin
            dims_we    = cmd.exec;
            time_we    = cmd.exec;
            set_vb     = 1'b1;
            res_status = ST_FILLED;
          end else begin
            res_status = ST_ALLOC_FAIL;
          end
        end else if (vic_found_r) begin
          wr_slot   = vic_idx_r;
          res_grant = GRANT_W'(vic_idx_r);
          res_disc  = 1'b1;
          if (req_ok_r) begin
            dims_we    = cmd.exec;
            time_we    = cmd.exec;
            set_vb     = 1'b1;
            res_status = ST_REPLACED;
          end else begin
            clr_slot   = 1'b1;
            res_status = ST_ALLOC_FAIL;
          end
        end else begin
          res_status = ST_NONE_FREE;
        end
      end
      CMD_RELEASE: begin
        res_grant = req_idx_r;
        wr_slot   = rel_slot;
        if (rel_ok) begin
          time_we    = cmd.exec;
          clr_busy   = 1'b1;
          res_status = ST_RELEASED;
        end else begin
          res_status = ST_NOT_POOLED;
          res_disc   = 1'b1;
        end
      end
      CMD_FLUSH: begin
        clr_all    = 1'b1;
        res_status = ST_FLUSHED;
        res_disc   = |valid_r;
      end
      default: begin
        res_status = ST_NOT_POOLED;
      end
    endcase
  end

  // Slot marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      busy_r  <= '0;
    end else if (cmd.exec) begin
      if (clr_all) begin
        valid_r <= '0;
        busy_r  <= '0;
      end else begin
        if (set_vb) begin
          valid_r[wr_slot] <= 1'b1;
          busy_r[wr_slot]  <= 1'b1;
        end
        if (set_busy) begin
          busy_r[wr_slot] <= 1'b1;
        end
        if (clr_busy) begin
          busy_r[wr_slot] <= 1'b0;
        end
        if (clr_slot) begin
          valid_r[wr_slot] <= 1'b0;
          busy_r[wr_slot]  <= 1'b0;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data_r <= {1'b0, res_disc, res_grant, res_status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/buffer_pool_lru_allocator.sv =====
// LRU buffer pool allocator, top level.
// Depends on bplru_pkg, bplru_ctrl, bplru_dp (and bplru_ram through the datapath).
//
// Usage:
//   Input channel in_*: one item per request. in_tuser carries the command
//   (acquire, release, flush); in_tdata carries width, height, now_ms,
//   alloc_ok and slot_index. Result channel out_*: exactly one item per
//   request, with status, granted_slot and discarded packed in out_tdata.
//   Sequencing: an acquire scans every slot through the slot RAMs, one slot
//   a cycle, then evaluates the last slot's read data and commits; release,
//   flush and the unused command skip the scan and go straight to commit.
//   Requests are handled one at a time; the next is taken the cycle after
//   the commit, even while the result waits in the output register.
//   Reset (rst_n low, synchronous) empties the pool: every slot is marked
//   invalid and not busy, and no result is pending. Slot sizes and times
//   need no clearing as their values only matter for valid slots.
//   If the receiver stalls, the result is held in the output register and
//   a following request completes its scan, then waits before committing.
module buffer_pool_lru_allocator
  import bplru_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [15:0] width, [31:16] height, [63:32] now_ms, [64] alloc_ok,
  // [67:65] slot_index, [71:68] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] command
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [2:0] status, [5:3] granted_slot, [6] discarded, [7] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer
  bplru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Slot state and decision logic
  bplru_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
